### hw/rtl/rcrm_pkg.sv
// ----------------------------------------------------------------------------
// rcrm_pkg
// Shared types and constants of the row colour run merger.
// ----------------------------------------------------------------------------
package rcrm_pkg;

  localparam int unsigned TolW        = 12;
  localparam int unsigned LenW        = 13;
  localparam int unsigned MaxRowWidth = 4096;
  localparam int unsigned TolMin      = 1;
  localparam int unsigned TolMax      = 3000;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned DivBits     = 8;

  // calculation phases, one per cycle
  localparam logic [2:0] PhSq   = 3'd0;
  localparam logic [2:0] PhDist = 3'd1;
  localparam logic [2:0] PhNq   = 3'd2;
  localparam logic [2:0] PhSs   = 3'd3;
  localparam logic [2:0] PhDev  = 3'd4;
  localparam logic [2:0] PhDd   = 3'd5;
  localparam logic [2:0] PhPass = 3'd6;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       row_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0]      run_red;
    logic [7:0]      run_green;
    logic [7:0]      run_blue;
    logic [7:0]      run_opacity;
    logic [LenW-1:0] run_length;
    logic            row_done;
  } run_t;

  typedef struct packed {
    logic       accept;
    logic       calc;
    logic [2:0] phase;
    logic       div_init;
    logic       div_step;
    logic [2:0] div_bit;
    logic       out_load;
    logic       out_done;
    logic       upd;
    logic       row_clear;
  } cmd_t;

  typedef struct packed {
    logic join_run;
    logic row_start;
    logic row_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/rcrm_datapath.sv
// ----------------------------------------------------------------------------
// rcrm_datapath
// Run accumulators, merge test lanes, mean dividers and output register.
// ----------------------------------------------------------------------------
module rcrm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [11:0]           cfg_data_i,
  input  rcrm_pkg::pixel_t      in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rcrm_pkg::run_t        out_data_o,
  input  rcrm_pkg::cmd_t        cmd_i,
  output rcrm_pkg::sts_t        sts_o
);
  import rcrm_pkg::*;

  pixel_t          pix_q;
  logic [TolW-1:0] tol_q;
  logic [TolW-1:0] tol;
  logic [19:0]     sum_q [3];
  logic [27:0]     sq_q  [3];
  logic [LenW-1:0] len_q;
  logic [7:0]      alpha_q;
  logic [7:0]      prev_q [3];
  logic            row_start_q;

  logic [7:0]      px  [3];
  logic [7:0]      dif [3];
  logic [19:0]     s1  [3];
  logic [LenW-1:0] n1;

  logic [15:0]     psq_q [3];
  logic [15:0]     dsq_q [3];
  logic [27:0]     q1_q  [3];
  logic [40:0]     nq_q  [3];
  logic [39:0]     ss_q  [3];
  logic [40:0]     dev_q [3];
  logic [47:0]     dd_q  [3];
  logic [2:0]      dlt_q;
  logic [23:0]     tolsq_q;
  logic [23:0]     lim_q;
  logic [47:0]     limsq_q;
  logic            dist_ok_q;
  logic            colour_pass_q;

  logic [27:0]     ma [3];
  logic [23:0]     mb [3];
  logic [51:0]     mp [3];
  logic [23:0]     la, lb;
  logic [47:0]     lp;
  logic [17:0]     dist_sum;
  logic [49:0]     acc;
  logic            join_run;

  logic [21:0]     rem_q [3];
  logic [13:0]     dvs_q [3];
  logic [7:0]      quo_q [3];
  logic [21:0]     trial [3];

  logic            out_valid_q;
  run_t            out_data_q;

  always_comb begin
    px[0] = pix_q.pixel_red;
    px[1] = pix_q.pixel_green;
    px[2] = pix_q.pixel_blue;
    if (tol_q < TolW'(TolMin)) begin
      tol = TolW'(TolMin);
    end else if (tol_q > TolW'(TolMax)) begin
      tol = TolW'(TolMax);
    end else begin
      tol = tol_q;
    end
    n1 = len_q + LenW'(1);
    for (int c = 0; c < 3; c++) begin
      s1[c]  = sum_q[c] + 20'(px[c]);
      dif[c] = (px[c] > prev_q[c]) ? px[c] - prev_q[c] : prev_q[c] - px[c];
      ma[c]  = '0;
      mb[c]  = '0;
      case (cmd_i.phase)
        PhSq: begin
          ma[c] = 28'(px[c]);
          mb[c] = 24'(px[c]);
        end
        PhDist: begin
          ma[c] = 28'(dif[c]);
          mb[c] = 24'(dif[c]);
        end
        PhNq: begin
          ma[c] = q1_q[c];
          mb[c] = 24'(n1);
        end
        PhSs: begin
          ma[c] = 28'(s1[c]);
          mb[c] = 24'(s1[c]);
        end
        PhDd: begin
          ma[c] = 28'(dev_q[c][23:0]);
          mb[c] = dev_q[c][23:0];
        end
        default: ;
      endcase
      mp[c] = 52'(ma[c]) * 52'(mb[c]);
      trial[c] = 22'(dvs_q[c]) << cmd_i.div_bit;
    end
    la = '0;
    lb = '0;
    case (cmd_i.phase)
      PhSq: begin
        la = 24'(tol);
        lb = 24'(tol);
      end
      PhDist: begin
        la = 24'(tol);
        lb = 24'(n1);
      end
      PhDd: begin
        la = lim_q;
        lb = lim_q;
      end
      default: ;
    endcase
    lp       = 48'(la) * 48'(lb);
    dist_sum = 18'(dsq_q[0]) + 18'(dsq_q[1]) + 18'(dsq_q[2]);
    acc      = 50'(dd_q[0]) + 50'(dd_q[1]) + 50'(dd_q[2]);
    join_run = (pix_q.pixel_alpha == alpha_q) && (len_q < LenW'(MaxRowWidth)) &&
               ((pix_q.pixel_alpha == 8'd0) || colour_pass_q);
  end

  // merge test pipeline, one phase per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= in_data_i;
    end
    if (cmd_i.calc) begin
      case (cmd_i.phase)
        PhSq: begin
          for (int c = 0; c < 3; c++) psq_q[c] <= mp[c][15:0];
          tolsq_q <= lp[23:0];
        end
        PhDist: begin
          for (int c = 0; c < 3; c++) begin
            dsq_q[c] <= mp[c][15:0];
            q1_q[c]  <= sq_q[c] + 28'(psq_q[c]);
          end
          lim_q <= lp[23:0];
        end
        PhNq: begin
          for (int c = 0; c < 3; c++) nq_q[c] <= mp[c][40:0];
          dist_ok_q <= 24'(dist_sum) < tolsq_q;
        end
        PhSs: begin
          for (int c = 0; c < 3; c++) ss_q[c] <= mp[c][39:0];
        end
        PhDev: begin
          for (int c = 0; c < 3; c++) begin
            dev_q[c] <= (nq_q[c] > 41'(ss_q[c])) ? nq_q[c] - 41'(ss_q[c]) : '0;
          end
        end
        PhDd: begin
          for (int c = 0; c < 3; c++) begin
            dd_q[c]  <= mp[c][47:0];
            dlt_q[c] <= dev_q[c] < 41'(lim_q);
          end
          limsq_q <= lp;
        end
        PhPass: begin
          colour_pass_q <= dist_ok_q && (&dlt_q) && (acc < 50'(limsq_q));
        end
        default: ;
      endcase
    end
  end

  // restoring divide for the rounded mean: (2*sum + n) / (2*n)
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.div_init) begin
        rem_q[c] <= 22'({sum_q[c], 1'b0}) + 22'(len_q);
        dvs_q[c] <= {len_q, 1'b0};
        quo_q[c] <= '0;
      end else if (cmd_i.div_step && rem_q[c] >= trial[c]) begin
        rem_q[c] <= rem_q[c] - trial[c];
        quo_q[c][cmd_i.div_bit] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TolW'(TolMin);
      len_q       <= '0;
      alpha_q     <= '0;
      row_start_q <= 1'b1;
      for (int c = 0; c < 3; c++) begin
        sum_q[c]  <= '0;
        sq_q[c]   <= '0;
        prev_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      if (cmd_i.upd) begin
        for (int c = 0; c < 3; c++) begin
          prev_q[c] <= px[c];
          if (row_start_q || !join_run) begin
            sum_q[c] <= 20'(px[c]);
            sq_q[c]  <= 28'(psq_q[c]);
          end else begin
            sum_q[c] <= s1[c];
            sq_q[c]  <= q1_q[c];
          end
        end
        if (row_start_q || !join_run) begin
          len_q   <= LenW'(1);
          alpha_q <= pix_q.pixel_alpha;
        end else begin
          len_q <= n1;
        end
        row_start_q <= 1'b0;
      end
      if (cmd_i.row_clear) begin
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= '0;
          sq_q[c]  <= '0;
        end
        len_q       <= '0;
        alpha_q     <= '0;
        row_start_q <= 1'b1;
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.run_red     <= quo_q[0];
      out_data_q.run_green   <= quo_q[1];
      out_data_q.run_blue    <= quo_q[2];
      out_data_q.run_opacity <= alpha_q;
      out_data_q.run_length  <= len_q;
      out_data_q.row_done    <= cmd_i.out_done;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;
  assign sts_o.join_run   = join_run;
  assign sts_o.row_start  = row_start_q;
  assign sts_o.row_last   = pix_q.row_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### hw/rtl/rcrm_ctrl.sv
// ----------------------------------------------------------------------------
// rcrm_ctrl
// Sequencer: accept, merge test phases, decision, mean divide, emit, update, row clear.
// ----------------------------------------------------------------------------
module rcrm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output rcrm_pkg::cmd_t cmd_o,
  input  rcrm_pkg::sts_t sts_i
);
  import rcrm_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCalc   = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;
  localparam logic [2:0] StUpd    = 3'd5;
  localparam logic [2:0] StClr    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       final_q, final_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    final_d    = final_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc  = 1'b1;
        cmd_o.phase = cnt_q[2:0];
        cnt_d       = cnt_q + 4'd1;
        if (cnt_q == 4'(NumPhases - 1)) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        // a pixel that fails to join closes the open run first
        if (!sts_i.row_start && !sts_i.join_run) begin
          cnt_d   = '0;
          final_d = 1'b0;
          state_d = StDiv;
        end else begin
          state_d = StUpd;
        end
      end
      StDiv: begin
        if (cnt_q == 4'd0) begin
          cmd_o.div_init = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
          cmd_o.div_bit  = 3'(4'(DivBits) - cnt_q);
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DivBits)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_done = final_q;
          state_d        = final_q ? StClr : StUpd;
        end
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        if (sts_i.row_last) begin
          final_d = 1'b1;
          cnt_d   = '0;
          state_d = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StClr: begin
        cmd_o.row_clear = 1'b1;
        final_d         = 1'b0;
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      final_q <= final_d;
    end
  end

endmodule

### hw/rtl/row_colour_run_merger_core.sv
// ----------------------------------------------------------------------------
// row_colour_run_merger_core
// Groups row pixels into runs of equal alpha and reports mean colour runs.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. A pixel that joins the open run goes
// from acceptance to the next ready through an accept step, seven phases
// of the merge test (one multiplier per colour lane plus one for the
// tolerance limit, one product per cycle), a decision and an update. A pixel
// that closes a run adds the 8-step mean divider and the output load; a
// row's last pixel adds another divide and output load for its own run plus
// the row clear. The output register lets a finished run wait while the next pixel
// is taken; the sequencer only stalls when a second result finds it full.
module row_colour_run_merger_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [11:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rcrm_pkg::pixel_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rcrm_pkg::run_t   out_data_o
);
  import rcrm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rcrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rcrm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef ASSERT_OFF
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while a pixel is in work");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_length != '0) &&
                    (out_data_o.run_length <= LenW'(MaxRowWidth)))
    else $error("run length out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while full");
`endif

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the row colour run merger: pixel requests go in over valid/ready,
// run results come back and are compared against an in-bench run tracker.
// ----------------------------------------------------------------------------
module tb_top;
  import rcrm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pixel_t      in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  run_t        out_data_o;

  row_colour_run_merger_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // run tracker state
  logic [11:0]   tol_reg;
  longint unsigned acc_r, acc_g, acc_b, acc_qr, acc_qg, acc_qb, run_len;
  logic [7:0]    run_a;
  logic [23:0]   prev_rgb;
  bit            row_open;
  run_t          runs_due[$];

  int  mismatches = 0;
  int  results_seen = 0;
  bit  gaps_on = 1'b1;
  bit  hold_rx = 1'b0;
  int  row_pos = 0;

  function automatic logic [7:0] mean8(longint unsigned s, longint unsigned n);
    return 8'((2 * s + n) / (2 * n));
  endfunction

  function automatic run_t close_run(bit done);
    run_t r;
    r.run_red     = mean8(acc_r, run_len);
    r.run_green   = mean8(acc_g, run_len);
    r.run_blue    = mean8(acc_b, run_len);
    r.run_opacity = run_a;
    r.run_length  = LenW'(run_len);
    r.row_done    = done;
    return r;
  endfunction

  function automatic longint unsigned scaled_dev(longint unsigned s, longint unsigned q,
                                                 longint unsigned n1);
    longint unsigned x, y;
    x = n1 * q;
    y = s * s;
    return (x > y) ? x - y : 0;
  endfunction

  function automatic bit colour_match(longint unsigned r, longint unsigned g,
                                      longint unsigned b, longint unsigned tol);
    longint signed   dr, dg, db;
    longint unsigned n1, lim, d0, d1, d2;
    dr = longint'(prev_rgb[23:16]) - longint'(r);
    dg = longint'(prev_rgb[15:8]) - longint'(g);
    db = longint'(prev_rgb[7:0]) - longint'(b);
    if (longint'(dr * dr + dg * dg + db * db) >= longint'(tol * tol)) return 1'b0;
    n1  = run_len + 1;
    lim = tol * n1;
    d0  = scaled_dev(acc_r + r, acc_qr + r * r, n1);
    d1  = scaled_dev(acc_g + g, acc_qg + g * g, n1);
    d2  = scaled_dev(acc_b + b, acc_qb + b * b, n1);
    if (d0 >= lim || d1 >= lim || d2 >= lim) return 1'b0;
    return (d0 * d0 + d1 * d1 + d2 * d2) < lim * lim;
  endfunction

  task automatic start_run(pixel_t p);
    acc_r = p.pixel_red;  acc_g = p.pixel_green;  acc_b = p.pixel_blue;
    acc_qr = acc_r * acc_r; acc_qg = acc_g * acc_g; acc_qb = acc_b * acc_b;
    run_len = 1;
    run_a = p.pixel_alpha;
  endtask

  task automatic predict_runs(pixel_t p);
    longint unsigned tol, r, g, b;
    bit joins;
    tol = (tol_reg == 0) ? TolMin : (tol_reg > TolMax) ? TolMax : tol_reg;
    r = p.pixel_red; g = p.pixel_green; b = p.pixel_blue;
    if (!row_open) begin
      start_run(p);
    end else begin
      joins = (p.pixel_alpha == run_a) && (run_len < MaxRowWidth) &&
              (p.pixel_alpha == 0 || colour_match(r, g, b, tol));
      if (joins) begin
        acc_r += r; acc_g += g; acc_b += b;
        acc_qr += r * r; acc_qg += g * g; acc_qb += b * b;
        run_len++;
      end else begin
        runs_due.push_back(close_run(1'b0));
        start_run(p);
      end
    end
    prev_rgb = {p.pixel_red, p.pixel_green, p.pixel_blue};
    if (p.row_last) begin
      runs_due.push_back(close_run(1'b1));
      run_len = 0;
      run_a = '0;
      row_open = 1'b0;
    end else begin
      row_open = 1'b1;
    end
  endtask

  // valid stays up between back-to-back requests; drop it only for an idle gap
  task automatic send_pixel(pixel_t p);
    if (gaps_on && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (gaps_on && $urandom_range(99) < 38);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    predict_runs(p);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    // closing pixels may still be in the pipe
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [11:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tol_reg = v;
  endtask

  function automatic pixel_t rand_pixel(bit last);
    pixel_t p;
    p.pixel_red   = 8'($urandom);
    p.pixel_green = 8'($urandom);
    p.pixel_blue  = 8'($urandom);
    p.pixel_alpha = 8'($urandom);
    p.row_last    = last;
    return p;
  endfunction

  // near neighbour of the previous pixel so runs actually grow
  function automatic pixel_t near_pixel(pixel_t base, int spread, bit last);
    pixel_t p;
    p = base;
    p.pixel_red   = 8'(int'(base.pixel_red) + $urandom_range(2 * spread) - spread);
    p.pixel_green = 8'(int'(base.pixel_green) + $urandom_range(2 * spread) - spread);
    p.pixel_blue  = 8'(int'(base.pixel_blue) + $urandom_range(2 * spread) - spread);
    p.row_last    = last;
    return p;
  endfunction

  task automatic test_extremes();
    write_tol(12'd0);
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
    send_pixel('{8'h12, 8'h34, 8'h56, 8'h80, 1'b1});
    write_tol(12'hFFF);
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h01, 1'b0});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0});
    send_pixel('{8'h00, 8'hFF, 8'h00, 8'h01, 1'b0});
    send_pixel('{8'hFF, 8'h00, 8'hFF, 8'h02, 1'b1});
    write_tol(12'd3000);
    send_pixel('{8'h10, 8'h20, 8'h30, 8'h05, 1'b0});
    send_pixel('{8'h11, 8'h21, 8'h31, 8'h05, 1'b1});
  endtask

  task automatic test_transparent();
    write_tol(12'd2);
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    send_pixel('{8'hFF, 8'h80, 8'h01, 8'h00, 1'b0});
    send_pixel('{8'h7F, 8'hFF, 8'hAA, 8'h00, 1'b0});
    send_pixel('{8'h01, 8'h02, 8'h03, 8'h00, 1'b1});
  endtask

  task automatic test_random_rows(int n_items);
    pixel_t p;
    int sent, len, spread;
    logic [11:0] tols[4];
    tols = '{12'd1, 12'd40, 12'd400, 12'd3000};
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_tol(tols[$urandom_range(3)]);
      else if ($urandom_range(5) == 0) write_tol(12'($urandom));
      len    = $urandom_range(1, 24);
      spread = $urandom_range(0, 20);
      p = rand_pixel(len == 1);
      if ($urandom_range(4) == 0) p.pixel_alpha = 8'h00;
      send_pixel(p);
      sent++;
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(9) == 0) p = rand_pixel(i == len - 1);
        else if ($urandom_range(12) == 0) begin
          p = near_pixel(p, spread, i == len - 1);
          p.pixel_alpha = 8'($urandom);
        end else p = near_pixel(p, spread, i == len - 1);
        send_pixel(p);
        sent++;
      end
      // quiet stretch with back-to-back traffic
      gaps_on = !(sent > n_items / 3 && sent < n_items / 2);
    end
    gaps_on = 1'b1;
  endtask

  // receiver
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= !hold_rx && !(gaps_on && $urandom_range(99) < 38);
    end
  end

  // hold off the receiver for a long stretch so the block backs up
  initial begin
    int hold;
    @(posedge rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_rx = 1'b1;
    for (hold = 0; hold < 400; hold++) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (runs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected run result %p", out_data_o);
      end else begin
        run_t want;
        want = runs_due.pop_front();
        if (out_data_o.run_red != want.run_red || out_data_o.run_green != want.run_green ||
            out_data_o.run_blue != want.run_blue ||
            out_data_o.run_opacity != want.run_opacity ||
            out_data_o.run_length != want.run_length ||
            out_data_o.row_done != want.row_done) begin
          mismatches++;
          if (mismatches <= 10) $display("run mismatch: want %p got %p", want, out_data_o);
        end
      end
    end
  end

  initial begin
    tol_reg = 12'd1;
    row_open = 1'b0;
    run_len = 0;
    run_a = '0;
    prev_rgb = '0;
    acc_r = 0; acc_g = 0; acc_b = 0; acc_qr = 0; acc_qg = 0; acc_qb = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_transparent();
    test_random_rows(500);
    drain();
    if (runs_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/rcrm_pkg.sv
hw/rtl/rcrm_datapath.sv
hw/rtl/rcrm_ctrl.sv
hw/rtl/row_colour_run_merger_core.sv
verif/tb_top.sv
